// ----- src/utf8tc_pkg.sv -----
// Shared types, constants and mapping functions for the Turkish UTF-8 case folder.
package utf8tc_pkg;

  // Configuration register values
  localparam logic MODE_UPPER = 1'b0;
  localparam logic MODE_FOLD  = 1'b1;

  // Results allowed per request, and job queue size
  localparam int MAX_RESULTS = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Characters and lead byte masks
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;
  localparam logic [7:0] DOT_I_B0   = 8'hC4;
  localparam logic [7:0] DOT_I_B1   = 8'hB0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;

  // One complete unit of work: up to four bytes to scan
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            last;
    logic            mode;
  } job_t;

  // Queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Mapped output of one character: one or two bytes
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } map_t;

  // Sequence length from a lead byte; anything else counts as one
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] n;
    n = 3'd1;
    if ((c & LEAD2_MASK) == LEAD2_VAL) n = 3'd2;
    else if ((c & LEAD3_MASK) == LEAD3_VAL) n = 3'd3;
    else if ((c & LEAD4_MASK) == LEAD4_VAL) n = 3'd4;
    return n;
  endfunction

  // Map a single byte character
  function automatic map_t map_single(input logic mode, input logic [7:0] c);
    map_t m;
    m.two = 1'b0;
    m.b0  = c;
    m.b1  = c;
    if (mode == MODE_UPPER && c == CH_LOWER_I) begin
      m.two = 1'b1;
      m.b0  = DOT_I_B0;
      m.b1  = DOT_I_B1;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      m.b0 = c - CASE_DIFF;
    end
    return m;
  endfunction

  // Map a two byte sequence; unknown pairs pass through
  function automatic map_t map_pair(input logic mode, input logic [7:0] a,
                                    input logic [7:0] b);
    map_t m;
    m.two = 1'b1;
    m.b0  = a;
    m.b1  = b;
    if (mode == MODE_UPPER) begin
      case ({a, b})
        16'hC4B1: begin m.two = 1'b0; m.b0 = 8'h49; end
        16'hC3A7: m.b1 = 8'h87;
        16'hC49F: m.b1 = 8'h9E;
        16'hC3B6: m.b1 = 8'h96;
        16'hC59F: m.b1 = 8'h9E;
        16'hC3BC: m.b1 = 8'h9C;
        default: m.two = 1'b1;
      endcase
    end else begin
      case ({a, b})
        16'hC4B1, 16'hC4B0: begin m.two = 1'b0; m.b0 = 8'h49; end
        16'hC3A7, 16'hC387: begin m.two = 1'b0; m.b0 = 8'h43; end
        16'hC49F, 16'hC49E: begin m.two = 1'b0; m.b0 = 8'h47; end
        16'hC3B6, 16'hC396: begin m.two = 1'b0; m.b0 = 8'h4F; end
        16'hC59F, 16'hC59E: begin m.two = 1'b0; m.b0 = 8'h53; end
        16'hC3BC, 16'hC39C: begin m.two = 1'b0; m.b0 = 8'h55; end
        default: m.two = 1'b1;
      endcase
    end
    return m;
  endfunction

endpackage

// ----- src/utf8tc_intf.sv -----
// Channel interfaces: input bytes, result bytes and the mode register write.
interface utf8tc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;
  modport source (output valid, in_byte, is_last, input ready);
  modport sink (input valid, in_byte, is_last, output ready);
endinterface

interface utf8tc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;
  modport source (output valid, out_byte, run_end, string_end, input ready);
  modport sink (input valid, out_byte, run_end, string_end, output ready);
endinterface

interface utf8tc_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

// ----- src/utf8tc_front.sv -----
// Front end: takes bytes, holds incomplete sequences and forms scan jobs.
module utf8tc_front (
  input  logic                 clk,
  input  logic                 rst,
  utf8tc_cfg_if.sink           cfg_ch,
  utf8tc_in_if.sink            in_ch,
  input  utf8tc_pkg::q_status_t q_status,
  output logic                 push,
  output utf8tc_pkg::job_t     push_job
);

  logic [7:0] held [3];
  logic [1:0] held_count;
  logic       mode;

  logic       accept;
  logic [2:0] lead_n;
  logic       form;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_status.full;
  assign accept       = in_ch.valid && in_ch.ready;

  // Assemble held bytes and the new byte into a job
  always_comb begin
    push_job.bytes[0] = (held_count > 2'd0) ? held[0] : in_ch.in_byte;
    push_job.bytes[1] = (held_count > 2'd1) ? held[1] : in_ch.in_byte;
    push_job.bytes[2] = (held_count > 2'd2) ? held[2] : in_ch.in_byte;
    push_job.bytes[3] = in_ch.in_byte;
    push_job.len      = {1'b0, held_count} + 3'd1;
    push_job.last     = in_ch.is_last;
    push_job.mode     = mode;
    lead_n = utf8tc_pkg::lead_len((held_count == 2'd0) ? in_ch.in_byte : held[0]);
    form   = in_ch.is_last || (push_job.len == lead_n);
  end

  assign push = accept && form;

  // Update mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= utf8tc_pkg::MODE_UPPER;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      mode <= cfg_ch.mode;
    end
  end

  // Hold incomplete sequence bytes; drop them once a job forms
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      if (form) begin
        held_count <= 2'd0;
      end else begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  // Store the byte of a request that leaves the sequence open
  always_ff @(posedge clk) begin
    if (accept && !form) begin
      held[held_count] <= in_ch.in_byte;
    end
  end

endmodule

// ----- src/utf8tc_queue.sv -----
// Job queue between the front end and the back end.
module utf8tc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  utf8tc_pkg::job_t      push_job,
  input  logic                  pop,
  output utf8tc_pkg::job_t      head,
  output utf8tc_pkg::q_status_t q_status
);

  localparam int CNT_W = utf8tc_pkg::QPTR_W + 1;

  utf8tc_pkg::job_t                 mem [utf8tc_pkg::QUEUE_DEPTH];
  logic [utf8tc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [utf8tc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]                 count;

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == CNT_W'(utf8tc_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + utf8tc_pkg::QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + utf8tc_pkg::QPTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  // Write job storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

endmodule

// ----- src/utf8tc_back.sv -----
// Back end: scans the head job and emits converted bytes one per cycle while out_ch is ready.
module utf8tc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  utf8tc_pkg::job_t      head,
  input  utf8tc_pkg::q_status_t q_status,
  output logic                  pop,
  utf8tc_out_if.source          out_ch
);

  localparam logic [2:0] RES_LAST = 3'(utf8tc_pkg::MAX_RESULTS - 1);

  logic [1:0] idx;
  logic [1:0] sub;
  logic [2:0] res_cnt;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  logic       step;
  logic [7:0] c;
  logic [2:0] n;
  logic       fits;
  logic [2:0] u_cnt;
  logic [2:0] u_adv;
  logic [7:0] u_out;
  logic       unit_done;
  logic [2:0] next_pos;
  logic       job_done;
  utf8tc_pkg::map_t m;

  assign out_ch.valid      = out_valid;
  assign out_ch.out_byte   = out_byte;
  assign out_ch.run_end    = run_end;
  assign out_ch.string_end = string_end;

  assign step = !q_status.empty && (!out_valid || out_ch.ready);

  // Decode the unit at the scan position and pick its current byte
  always_comb begin
    c     = head.bytes[idx];
    n     = utf8tc_pkg::lead_len(c);
    fits  = ({1'b0, idx} + n) <= head.len;
    m     = utf8tc_pkg::map_single(head.mode, c);
    u_cnt = 3'd1;
    u_adv = 3'd1;
    u_out = c;
    if (n == 3'd1) begin
      u_cnt = m.two ? 3'd2 : 3'd1;
      u_out = (sub == 2'd0) ? m.b0 : m.b1;
    end else if (fits && n == 3'd2) begin
      m     = utf8tc_pkg::map_pair(head.mode, c, head.bytes[idx + 2'd1]);
      u_cnt = m.two ? 3'd2 : 3'd1;
      u_adv = 3'd2;
      u_out = (sub == 2'd0) ? m.b0 : m.b1;
    end else if (fits) begin
      u_cnt = n;
      u_adv = n;
      u_out = head.bytes[idx + sub];
    end
    unit_done = ({1'b0, sub} == (u_cnt - 3'd1));
    next_pos  = {1'b0, idx} + u_adv;
    job_done  = (unit_done && next_pos >= head.len) || (res_cnt == RES_LAST);
  end

  assign pop = step && job_done;

  // Advance the scan position inside the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= 2'd0;
      sub     <= 2'd0;
      res_cnt <= 3'd0;
    end else if (step) begin
      if (job_done) begin
        idx     <= 2'd0;
        sub     <= 2'd0;
        res_cnt <= 3'd0;
      end else begin
        res_cnt <= res_cnt + 3'd1;
        if (unit_done) begin
          idx <= next_pos[1:0];
          sub <= 2'd0;
        end else begin
          sub <= sub + 2'd1;
        end
      end
    end
  end

  // Output register: load on step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte   <= u_out;
      run_end    <= job_done;
      string_end <= job_done && head.last;
    end
  end

endmodule

// ----- src/utf8_turkish_case_fold.sv -----
// Top level of the streaming Turkish-locale UTF-8 case converter.
// Usage:
//   in_ch carries one byte of a UTF-8 string per request, is_last on the
//   final byte. out_ch returns the converted string one byte per request;
//   run_end marks the last byte caused by an input byte and string_end the
//   final byte of the whole string. cfg_ch writes mode (0 Turkish uppercase,
//   1 fold to ASCII key); always ready; user must write it while idle (unchecked).
// Timing:
//   A byte that completes a sequence yields its first result through the job
//   queue and the output register; bytes that leave a sequence open yield
//   nothing. One input byte is taken per cycle while the four-entry job
//   queue has room. The back end emits one result byte per cycle while out_ch
//   is ready, so an input expanding to k bytes holds it until all k are out;
//   the scan unit sets the sustained rate; the queue absorbs short bursts.
// Reset:
//   Synchronous rst clears held bytes, empties the queue and sets mode 0.
// Stalls:
//   With out_ch.ready low the output register holds its byte, the queue
//   fills, and in_ch.ready drops once four jobs are waiting.
module utf8_turkish_case_fold (
  input  logic          clk,
  input  logic          rst,
  utf8tc_cfg_if.sink    cfg_ch,
  utf8tc_in_if.sink     in_ch,
  utf8tc_out_if.source  out_ch
);

  utf8tc_pkg::q_status_t q_status;
  utf8tc_pkg::job_t      push_job;
  utf8tc_pkg::job_t      head;
  logic                  push;
  logic                  pop;

  utf8tc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_ch   (cfg_ch),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  utf8tc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  utf8tc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  a_string_end_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.string_end) |-> out_ch.run_end)
    else $error("string end without run end");

  a_pop_marks_run_end: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_ch.valid && out_ch.run_end))
    else $error("finished job did not flag run end");
`endif

endmodule

// ----- dv/utf8tc_fold_check.sv -----
`timescale 1ns / 100ps
// Scoreboard for the case folder: tracks mode and held bytes, predicts and checks result bytes.
module utf8tc_fold_check (
  input  logic  clk,
  input  logic  rst,
  utf8tc_cfg_if cfg_ch,
  utf8tc_in_if  in_ch,
  utf8tc_out_if out_ch,
  output int    fail_count,
  output int    bytes_owed,
  output int    bytes_checked
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } conv_byte_t;

  // Shadow of the mode register and of the open sequence
  logic       mode_q;
  logic [7:0] held [3];
  int         held_cnt;

  // Bytes produced by the current request, and all converted bytes still owed
  conv_byte_t step_bytes [$];
  conv_byte_t folded_q [$];

  // Sequence length announced by a byte
  function automatic int seq_len(input logic [7:0] c);
    if (c < 8'h80) return 1;
    if ((c & utf8tc_pkg::LEAD2_MASK) == utf8tc_pkg::LEAD2_VAL) return 2;
    if ((c & utf8tc_pkg::LEAD3_MASK) == utf8tc_pkg::LEAD3_VAL) return 3;
    if ((c & utf8tc_pkg::LEAD4_MASK) == utf8tc_pkg::LEAD4_VAL) return 4;
    return 1;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    conv_byte_t r;
    r.out_byte   = b;
    r.run_end    = 1'b0;
    r.string_end = 1'b0;
    if (step_bytes.size() < utf8tc_pkg::MAX_RESULTS) step_bytes.push_back(r);
  endtask

  // Convert one single-byte character
  task automatic put_char(input logic [7:0] c);
    if (mode_q == utf8tc_pkg::MODE_UPPER && c == utf8tc_pkg::CH_LOWER_I) begin
      put_byte(utf8tc_pkg::DOT_I_B0);
      put_byte(utf8tc_pkg::DOT_I_B1);
    end else if (c >= utf8tc_pkg::CH_LOWER_A && c <= utf8tc_pkg::CH_LOWER_Z) begin
      put_byte(c - utf8tc_pkg::CASE_DIFF);
    end else begin
      put_byte(c);
    end
  endtask

  // Convert one two-byte sequence; unknown pairs pass through
  task automatic put_pair(input logic [7:0] a, input logic [7:0] b);
    if (mode_q == utf8tc_pkg::MODE_UPPER) begin
      case ({a, b})
        16'hC4B1: put_byte(8'h49);
        16'hC3A7: begin put_byte(8'hC3); put_byte(8'h87); end
        16'hC49F: begin put_byte(8'hC4); put_byte(8'h9E); end
        16'hC3B6: begin put_byte(8'hC3); put_byte(8'h96); end
        16'hC59F: begin put_byte(8'hC5); put_byte(8'h9E); end
        16'hC3BC: begin put_byte(8'hC3); put_byte(8'h9C); end
        default: begin put_byte(a); put_byte(b); end
      endcase
    end else begin
      case ({a, b})
        16'hC4B1, 16'hC4B0: put_byte(8'h49);
        16'hC3A7, 16'hC387: put_byte(8'h43);
        16'hC49F, 16'hC49E: put_byte(8'h47);
        16'hC3B6, 16'hC396: put_byte(8'h4F);
        16'hC59F, 16'hC59E: put_byte(8'h53);
        16'hC3BC, 16'hC39C: put_byte(8'h55);
        default: begin put_byte(a); put_byte(b); end
      endcase
    end
  endtask

  // Scan held bytes plus the new one, queue what comes out, keep the open tail
  task automatic convert_byte(input logic [7:0] b, input logic last);
    logic [7:0] win [4];
    int         n_win;
    int         pos;
    int         n;
    logic       stop;
    conv_byte_t tail;
    n_win = held_cnt;
    for (int k = 0; k < n_win; k++) win[k] = held[k];
    win[n_win] = b;
    n_win++;
    step_bytes.delete();
    pos  = 0;
    stop = 1'b0;
    while (pos < n_win && !stop) begin
      n = seq_len(win[pos]);
      if (n == 1) begin
        put_char(win[pos]);
        pos++;
      end else if (pos + n <= n_win) begin
        if (n == 2) begin
          put_pair(win[pos], win[pos + 1]);
        end else begin
          for (int k = 0; k < n; k++) put_byte(win[pos + k]);
        end
        pos += n;
      end else if (last) begin
        // string ended inside a sequence: lead goes out alone, rest is rescanned
        put_byte(win[pos]);
        pos++;
      end else begin
        stop = 1'b1;
      end
    end
    held_cnt = 0;
    while (pos + held_cnt < n_win) begin
      held[held_cnt] = win[pos + held_cnt];
      held_cnt++;
    end
    // Mark the final byte of this request
    if (step_bytes.size() > 0) begin
      tail = step_bytes.pop_back();
      tail.run_end    = 1'b1;
      tail.string_end = last;
      step_bytes.push_back(tail);
    end
    foreach (step_bytes[k]) folded_q.push_back(step_bytes[k]);
  endtask

  // Track each channel at the rising edge and compare results in order
  always @(posedge clk) begin
    conv_byte_t want;
    if (rst) begin
      mode_q        = utf8tc_pkg::MODE_UPPER;
      held_cnt      = 0;
      folded_q.delete();
      fail_count    = 0;
      bytes_checked = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) mode_q = cfg_ch.mode;
      if (in_ch.valid && in_ch.ready) convert_byte(in_ch.in_byte, in_ch.is_last);
      if (out_ch.valid && out_ch.ready) begin
        if (folded_q.size() == 0) begin
          $error("out_byte: nothing expected, got %02h", out_ch.out_byte);
          fail_count++;
        end else begin
          want = folded_q.pop_front();
          bytes_checked++;
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, out_ch.run_end);
            fail_count++;
          end
          if (out_ch.string_end !== want.string_end) begin
            $error("string_end: expected %0b, got %0b", want.string_end,
                   out_ch.string_end);
            fail_count++;
          end
        end
      end
    end
    bytes_owed = folded_q.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Top of the case folder testbench: clock, reset, string stimulus and the verdict.
module tb;

  localparam int RAND_BYTES  = 400;
  localparam int PHASE_BYTES = 50;
  localparam int STALL_LIMIT = 2000;

  // Both cases of every Turkish-specific letter, dotted and dotless I included
  localparam logic [15:0] TR_PAIRS [12] = '{
    16'hC4B1, 16'hC4B0, 16'hC3A7, 16'hC387, 16'hC49F, 16'hC49E,
    16'hC3B6, 16'hC396, 16'hC59F, 16'hC59E, 16'hC3BC, 16'hC39C
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic no_idle = 1'b0;

  int fail_count;
  int bytes_owed;
  int bytes_checked;
  int bytes_sent = 0;
  int strings_sent = 0;
  int stall_cycles = 0;

  logic [7:0] str_bytes [$];

  utf8tc_cfg_if cfg_ch ();
  utf8tc_in_if  in_ch ();
  utf8tc_out_if out_ch ();

  utf8_turkish_case_fold u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8tc_fold_check u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_ch        (cfg_ch),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .bytes_owed    (bytes_owed),
    .bytes_checked (bytes_checked)
  );

  always #1 clk = ~clk;

  // End the run when no request moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Send one byte after a random gap; return at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    in_ch.is_last = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_string();
    foreach (str_bytes[k]) send_byte(str_bytes[k], k == str_bytes.size() - 1);
    strings_sent++;
  endtask

  // Drop the input, drain all owed results, then let the pipeline empty
  task automatic settle();
    in_ch.valid = 1'b0;
    do @(negedge clk); while (bytes_owed != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    settle();
    cfg_ch.valid = 1'b1;
    cfg_ch.mode  = m;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Continuation byte, now and then not one
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Mostly well-formed characters, some noise, sometimes an unfinished tail
  task automatic build_string();
    int         ntok;
    int         r;
    logic [15:0] pair;
    str_bytes.delete();
    ntok = $urandom_range(1, 10);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r = $urandom_range(0, 3);
          case (r)
            0: str_bytes.push_back(utf8tc_pkg::CH_LOWER_I);
            1: str_bytes.push_back(utf8tc_pkg::CH_LOWER_A + 8'($urandom_range(0, 25)));
            2: str_bytes.push_back(8'h41 + 8'($urandom_range(0, 25)));
            default: str_bytes.push_back(8'($urandom_range(0, 127)));
          endcase
        end
        4, 5: begin
          pair = TR_PAIRS[$urandom_range(0, 11)];
          str_bytes.push_back(pair[15:8]);
          str_bytes.push_back(pair[7:0]);
        end
        6: begin
          str_bytes.push_back(utf8tc_pkg::LEAD2_VAL | 8'($urandom_range(0, 31)));
          str_bytes.push_back(cont_byte());
        end
        7: begin
          str_bytes.push_back(utf8tc_pkg::LEAD3_VAL | 8'($urandom_range(0, 15)));
          repeat (2) str_bytes.push_back(cont_byte());
        end
        8: begin
          str_bytes.push_back(utf8tc_pkg::LEAD4_VAL | 8'($urandom_range(0, 7)));
          repeat (3) str_bytes.push_back(cont_byte());
        end
        default: str_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // Cut the string off inside a sequence
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0: str_bytes.push_back(utf8tc_pkg::LEAD2_VAL | 8'($urandom_range(0, 31)));
        1: begin
          str_bytes.push_back(utf8tc_pkg::LEAD3_VAL | 8'($urandom_range(0, 15)));
          repeat ($urandom_range(0, 1)) str_bytes.push_back(cont_byte());
        end
        default: begin
          str_bytes.push_back(utf8tc_pkg::LEAD4_VAL | 8'($urandom_range(0, 7)));
          repeat ($urandom_range(0, 2)) str_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin
    int dir_bytes;
    int phase;
    int phase_start;
    cfg_ch.valid  = 1'b0;
    cfg_ch.mode   = utf8tc_pkg::MODE_UPPER;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.is_last = 1'b0;
    rst           = 1'b1;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Uppercase mode: letters, byte extremes, Turkish pairs, pass-through,
    // overlong lead, and a string that ends inside a four-byte sequence
    str_bytes = '{8'h69, 8'h7A, 8'h00, 8'hFF, 8'hC4, 8'hB1, 8'hC3, 8'hA7,
                  8'hE2, 8'h82, 8'hAC, 8'hC1, 8'h41, 8'hF0, 8'h69, 8'h69};
    send_string();

    // Switch mode while a lead byte is held; the new mode applies to the pair
    send_byte(8'hC4, 1'b0);
    settle();
    set_mode(utf8tc_pkg::MODE_FOLD);
    send_byte(8'hB0, 1'b1);
    strings_sent++;

    // Fold mode: plain letters and an uppercase Turkish letter
    str_bytes = '{8'h61, 8'h69, 8'hC3, 8'h87};
    send_string();
    dir_bytes = bytes_sent;

    // Random phases, alternating modes, some without any idling
    phase = 0;
    while (bytes_sent < dir_bytes + RAND_BYTES) begin
      set_mode((phase % 2 == 0) ? utf8tc_pkg::MODE_UPPER : utf8tc_pkg::MODE_FOLD);
      no_idle     = (phase % 3 == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES &&
             bytes_sent < dir_bytes + RAND_BYTES) begin
        build_string();
        send_string();
      end
      phase++;
    end

    // Drain and let the block go quiet
    in_ch.valid = 1'b0;
    no_idle     = 1'b0;
    do @(negedge clk); while (bytes_owed != 0);
    repeat (20) @(negedge clk);

    $display("summary: %0d input bytes in %0d strings, %0d result bytes checked",
             bytes_sent, strings_sent, bytes_checked);
    $display("summary: %0d random phases over both modes, truncated and broken sequences",
             phase);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
